[hdl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and reset
`define ASSERT_ON_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// assertion on the house clock and reset names
`define ASSERT_STD(lbl, prop) \
   `ASSERT_ON_CLK(lbl, clock, reset, prop)

`endif

[hdl/fbpa_pkg.sv]
`timescale 1ns / 1ps

package fbpa_pkg;

   // pool geometry
   localparam int POOL_BLOCKS = 64;
   localparam int BLK_W       = $clog2(POOL_BLOCKS);
   localparam int GRP_SIZE    = 8;
   localparam int GRP_W       = $clog2(GRP_SIZE);
   localparam int NUM_GRPS    = POOL_BLOCKS / GRP_SIZE;
   localparam int NGRP_W      = BLK_W - GRP_W;

   // field widths
   localparam int IDX_W    = 7;
   localparam int BYTES_W  = 17;
   localparam int OFFSET_W = 22;
   localparam int COUNT_W  = 7;
   localparam int PROD_W   = BLK_W + BYTES_W;

   localparam logic [BYTES_W-1:0]  BYTES_RESET = BYTES_W'(16);
   localparam logic [OFFSET_W-1:0] OFFSET_MAX  = '1;

   typedef enum logic {
      KIND_ALLOC   = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_FREE  = 2'd3
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [IDX_W-1:0]     block_index;
   } req_type;

   typedef struct packed {
      logic                 ok;
      status_type           status;
      logic [BLK_W-1:0]     granted_block;
      logic [OFFSET_W-1:0]  byte_offset;
      logic [COUNT_W-1:0]   used_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic commit;
      logic load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_held;
   } dp_stat_type;

endpackage

[hdl/fbpa_ctrl.sv]
`timescale 1ns / 1ps

module fbpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fbpa_pkg::dp_stat_type stat,
   output fbpa_pkg::dp_cmd_type  cmd
);
   import fbpa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DECIDE = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            // wait for the result register to free up
            if (!stat.out_held) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/fbpa_dp.sv]
`timescale 1ns / 1ps

module fbpa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::dp_cmd_type          cmd,
   output fbpa_pkg::dp_stat_type         stat,
   input  fbpa_pkg::req_type             req_data,
   input  logic                          csr_wr_en,
   input  logic [fbpa_pkg::BYTES_W-1:0]  csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fbpa_pkg::rsp_type             rsp_data
);
   import fbpa_pkg::*;

   // allocator state
   logic [POOL_BLOCKS-1:0] used_map_ff, used_map_in;
   logic [BLK_W-1:0]       search_start_ff, search_start_in;
   logic [BLK_W-1:0]       hint_ff, hint_in;
   logic                   hint_valid_ff, hint_valid_in;
   logic [COUNT_W-1:0]     used_total_ff, used_total_in;
   logic                   pool_full_ff, pool_full_in;
   logic [BYTES_W-1:0]     block_bytes_ff, block_bytes_in;

   // captured request and first scan level
   req_type                     req_ff;
   logic [NUM_GRPS-1:0]         grp_any_ff, grp_any_in;
   logic [NUM_GRPS*GRP_W-1:0]   grp_idx_ff, grp_idx_in;

   // decision
   logic                   ok_ff, ok_in;
   status_type             status_ff, status_in;
   logic [BLK_W-1:0]       grant_ff, grant_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [POOL_BLOCKS-1:0] free_rot;
   logic [NGRP_W-1:0]      grp_sel;
   logic [BLK_W-1:0]       scan_off;
   logic [BLK_W-1:0]       scan_blk;
   logic                   scan_any;
   logic                   hint_hit;
   logic [BLK_W-1:0]       rel_blk;
   logic [PROD_W-1:0]      prod;

   // free map rotated so that bit 0 is the search start
   always_comb begin
      for (int i = 0; i < POOL_BLOCKS; i++) begin
         free_rot[i] = ~used_map_ff[BLK_W'(search_start_ff + BLK_W'(i))];
      end
   end

   // per-group lowest free bit
   always_comb begin
      grp_idx_in = '0;
      for (int g = 0; g < NUM_GRPS; g++) begin
         grp_any_in[g] = |free_rot[g*GRP_SIZE +: GRP_SIZE];
         for (int j = GRP_SIZE - 1; j >= 0; j--) begin
            if (free_rot[g*GRP_SIZE + j]) begin
               grp_idx_in[g*GRP_W +: GRP_W] = GRP_W'(j);
            end
         end
      end
   end

   // lowest group with a free bit
   always_comb begin
      grp_sel = '0;
      for (int g = NUM_GRPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            grp_sel = NGRP_W'(g);
         end
      end
      scan_any = |grp_any_ff;
      scan_off = {grp_sel, grp_idx_ff[grp_sel*GRP_W +: GRP_W]};
      scan_blk = search_start_ff + scan_off;
   end

   assign hint_hit = hint_valid_ff && !used_map_ff[hint_ff];
   assign rel_blk  = req_ff.block_index[BLK_W-1:0];

   always_comb begin
      used_map_in     = used_map_ff;
      search_start_in = search_start_ff;
      hint_in         = hint_ff;
      hint_valid_in   = hint_valid_ff;
      used_total_in   = used_total_ff;
      pool_full_in    = pool_full_ff;
      ok_in           = ok_ff;
      status_in       = status_ff;
      grant_in        = grant_ff;
      if (cmd.commit) begin
         ok_in     = 1'b0;
         grant_in  = '0;
         status_in = ST_OK;
         if (req_ff.kind == KIND_ALLOC) begin
            if (pool_full_ff) begin
               status_in = ST_FULL;
            end else if (hint_hit) begin
               used_map_in[hint_ff] = 1'b1;
               hint_valid_in        = 1'b0;
               used_total_in        = used_total_ff + COUNT_W'(1);
               grant_in             = hint_ff;
               ok_in                = 1'b1;
            end else if (scan_any) begin
               used_map_in[scan_blk] = 1'b1;
               search_start_in       = scan_blk + BLK_W'(1);
               used_total_in         = used_total_ff + COUNT_W'(1);
               grant_in              = scan_blk;
               ok_in                 = 1'b1;
            end else begin
               pool_full_in    = 1'b1;
               search_start_in = BLK_W'(1 % POOL_BLOCKS);
               status_in       = ST_FULL;
            end
         end else begin
            if (req_ff.block_index >= IDX_W'(POOL_BLOCKS)) begin
               status_in = ST_RANGE;
            end else if (!used_map_ff[rel_blk]) begin
               status_in = ST_FREE;
            end else begin
               used_map_in[rel_blk] = 1'b0;
               hint_in              = rel_blk;
               hint_valid_in        = 1'b1;
               if (used_total_ff != '0) begin
                  used_total_in = used_total_ff - COUNT_W'(1);
               end
               pool_full_in = 1'b0;
               ok_in        = 1'b1;
            end
         end
      end
   end

   assign block_bytes_in = csr_wr_en ? csr_wr_data : block_bytes_ff;

   // byte offset with saturation
   always_comb begin
      prod                 = PROD_W'(grant_ff) * PROD_W'(block_bytes_ff);
      rsp_in.ok            = ok_ff;
      rsp_in.status        = status_ff;
      rsp_in.granted_block = grant_ff;
      rsp_in.byte_offset   = (prod > PROD_W'(OFFSET_MAX)) ? OFFSET_MAX
                                                          : prod[OFFSET_W-1:0];
      rsp_in.used_count    = used_total_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign stat.out_held = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_map_ff     <= '0;
         search_start_ff <= '0;
         hint_ff         <= '0;
         hint_valid_ff   <= 1'b0;
         used_total_ff   <= '0;
         pool_full_ff    <= 1'b0;
         block_bytes_ff  <= BYTES_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         used_map_ff     <= used_map_in;
         search_start_ff <= search_start_in;
         hint_ff         <= hint_in;
         hint_valid_ff   <= hint_valid_in;
         used_total_ff   <= used_total_in;
         pool_full_ff    <= pool_full_in;
         block_bytes_ff  <= block_bytes_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff     <= req_data;
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
      end
      ok_ff     <= ok_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[hdl/fixed_block_pool_allocator_core.sv]
`timescale 1ns / 1ps
// channel  ports                              direction  carries
// req      req_valid req_stall req_data       in         kind, block_index
// rsp      rsp_valid rsp_stall rsp_data       out        ok, status, block, offset, count
// csr      csr_wr_en csr_wr_data              in         block_bytes
//
// each request runs through capture plus group scan, then commit, then offset multiply
// the rotated find-first-free is split over two registered levels of 8 groups of 8
// reset is synchronous and clears the whole bitmap at once; block_bytes resets to 16
// a new request can be taken in the cycle after the previous beat enters the result register
// a stalled result holds the next result load until rsp_stall drops; one more request
// is still taken and committed meanwhile
module fixed_block_pool_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fbpa_pkg::req_type             req_data,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fbpa_pkg::rsp_type             rsp_data,
   // block size register
   input  logic                          csr_wr_en,
   input  logic [fbpa_pkg::BYTES_W-1:0]  csr_wr_data
);
   import fbpa_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: idle, decide, finish
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap, search position, reuse hint, counters and result register
   fbpa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[hdl/fbpa_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fbpa_pkg::rsp_type rsp_data
);
   import fbpa_pkg::*;

   `ASSERT_STD(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   `ASSERT_STD(a_ok_status, rsp_valid |-> (rsp_data.ok == (rsp_data.status == ST_OK)))

   `ASSERT_STD(a_fail_zero, rsp_valid && !rsp_data.ok |-> rsp_data.granted_block == '0 && rsp_data.byte_offset == '0)

   `ASSERT_STD(a_count_max, rsp_valid |-> rsp_data.used_count <= COUNT_W'(POOL_BLOCKS))

   `ASSERT_STD(a_busy_after_take, req_valid && !req_stall |=> req_stall)

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);

[dv/fixed_block_pool_allocator_core_test.sv]
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core_test;
   import fbpa_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 3;
   // a request passes through capture, commit and result load inside the block; this covers any beat in flight
   localparam int SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int IDLE_PCT = 37;
   localparam int REPORT_LIMIT = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [BYTES_W-1:0]  csr_wr_data = '0;

   // mirror of the allocator state, starting from its reset values
   logic [POOL_BLOCKS-1:0]  pool_map = '0;
   logic [BLK_W-1:0]        next_search = '0;
   logic [BLK_W-1:0]        hint_block = '0;
   bit                      hint_live = 1'b0;
   logic [COUNT_W-1:0]      blocks_used = '0;
   bit                      pool_exhausted = 1'b0;
   logic [BYTES_W-1:0]      block_size = BYTES_RESET;

   // responses the allocator still owes, oldest first
   rsp_type      awaited_rsp[$];
   rsp_type      want_rsp;
   int           fault_count = 0;
   int unsigned  cycle_count = 0;
   // clears for the stretch where neither side holds off
   bit           idle_on = 1'b1;

   fixed_block_pool_allocator_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // runs one request through the mirrored allocator and returns the response it owes
   function automatic rsp_type allocator_outcome(req_type r);
      rsp_type           o;
      bit                hit;
      int                k;
      logic [BLK_W-1:0]  pos;
      logic [BLK_W-1:0]  blk;
      logic [63:0]       prod;
      o = '0;
      o.status = ST_OK;
      hit = 1'b0;
      blk = '0;
      if (r.kind == KIND_ALLOC) begin
         if (pool_exhausted) begin
            // full pool refuses without touching anything
            o.status = ST_FULL;
         end else if (hint_live && !pool_map[hint_block]) begin
            // last freed block goes out first, search position stays put
            blk = hint_block;
            hint_live = 1'b0;
            hit = 1'b1;
         end else begin
            // next-fit scan, wrapping around the pool
            for (k = 0; k < POOL_BLOCKS; k++) begin
               pos = next_search + BLK_W'(k);
               if (!hit && !pool_map[pos]) begin
                  blk = pos;
                  hit = 1'b1;
               end
            end
            if (hit) begin
               next_search = blk + BLK_W'(1);
            end else begin
               pool_exhausted = 1'b1;
               next_search = BLK_W'(1);
               o.status = ST_FULL;
            end
         end
         if (hit) begin
            pool_map[blk] = 1'b1;
            blocks_used = blocks_used + 1'b1;
            o.ok = 1'b1;
            o.granted_block = blk;
            prod = 64'(blk) * 64'(block_size);
            // sizes beyond the documented range clip the offset
            o.byte_offset = (prod > 64'(OFFSET_MAX)) ? OFFSET_MAX : prod[OFFSET_W-1:0];
         end
      end else begin
         if (r.block_index >= POOL_BLOCKS) begin
            o.status = ST_RANGE;
         end else if (!pool_map[r.block_index[BLK_W-1:0]]) begin
            o.status = ST_FREE;
         end else begin
            pool_map[r.block_index[BLK_W-1:0]] = 1'b0;
            hint_block = r.block_index[BLK_W-1:0];
            hint_live = 1'b1;
            if (blocks_used != 0) blocks_used = blocks_used - 1'b1;
            pool_exhausted = 1'b0;
            o.ok = 1'b1;
         end
      end
      o.used_count = blocks_used;
      return o;
   endfunction

   // mostly a block that is really held, now and then any index at all
   function automatic logic [IDX_W-1:0] busy_block_or_noise();
      logic [IDX_W-1:0] idx;
      idx = IDX_W'($urandom_range(127));
      if ($urandom_range(99) < 10 || pool_map == '0) return idx;
      repeat (64) begin
         idx = IDX_W'($urandom_range(POOL_BLOCKS - 1));
         if (pool_map[idx[BLK_W-1:0]]) return idx;
      end
      return idx;
   endfunction

   // free-running watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side holds off at random while idling is on
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
   end

   // track register writes and accepted request beats at the same edge the block sees them
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) block_size = csr_wr_data;
         if (req_valid && !req_stall)
            awaited_rsp.insert(awaited_rsp.size(), allocator_outcome(req_data));
      end
   end

   // every accepted response beat is matched against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            if (fault_count < REPORT_LIMIT)
               $display("unexpected response beat: ok %0d status %0d block %0d offset %0d used %0d",
                        rsp_data.ok, rsp_data.status, rsp_data.granted_block,
                        rsp_data.byte_offset, rsp_data.used_count);
            fault_count++;
         end else begin
            want_rsp = awaited_rsp.pop_front();
            if (rsp_data.ok !== want_rsp.ok || rsp_data.status !== want_rsp.status ||
                rsp_data.granted_block !== want_rsp.granted_block ||
                rsp_data.byte_offset !== want_rsp.byte_offset ||
                rsp_data.used_count !== want_rsp.used_count) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("response mismatch at cycle %0d", cycle_count);
                  $display("  expected: ok %0d status %0d block %0d offset %0d used %0d",
                           want_rsp.ok, want_rsp.status, want_rsp.granted_block,
                           want_rsp.byte_offset, want_rsp.used_count);
                  $display("  actual:   ok %0d status %0d block %0d offset %0d used %0d",
                           rsp_data.ok, rsp_data.status, rsp_data.granted_block,
                           rsp_data.byte_offset, rsp_data.used_count);
               end
               fault_count++;
            end
         end
      end
   end

   // one request beat; valid stays up when the next beat follows without a gap
   task automatic send_request(kind_type op, logic [IDX_W-1:0] index);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: op, block_index: index};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and hold until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      // the beat accepted at the last edge is queued by now
      @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // block size only changes while the allocator is quiet
   task automatic write_block_size(logic [BYTES_W-1:0] size);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // fresh pool: next-fit grants, hint reuse, bad and double releases
   task automatic test_alloc_release_basics();
      send_request(KIND_ALLOC, 7'd0);
      send_request(KIND_ALLOC, 7'd127);
      send_request(KIND_ALLOC, 7'd85);
      send_request(KIND_RELEASE, 7'd1);
      // freed block comes straight back
      send_request(KIND_ALLOC, 7'd42);
      // search resumes after the last searched grant
      send_request(KIND_ALLOC, 7'd0);
      // indexes past the pool
      send_request(KIND_RELEASE, 7'd64);
      send_request(KIND_RELEASE, 7'd127);
      // never allocated, then a first release of block 0
      send_request(KIND_RELEASE, 7'd5);
      send_request(KIND_RELEASE, 7'd0);
      // double release
      send_request(KIND_RELEASE, 7'd0);
      send_request(KIND_ALLOC, 7'd127);
      // top valid index while free
      send_request(KIND_RELEASE, 7'd63);
   endtask

   // offsets across block sizes, zero and oversized included
   task automatic test_block_size_sweep();
      write_block_size(17'd1);
      send_request(KIND_ALLOC, 7'd3);
      write_block_size(17'd0);
      send_request(KIND_ALLOC, 7'd96);
      write_block_size(17'd65536);
      send_request(KIND_ALLOC, 7'd17);
      write_block_size(17'd131071);
      send_request(KIND_ALLOC, 7'd64);
      send_request(KIND_RELEASE, 7'd7);
      send_request(KIND_ALLOC, 7'd127);
   endtask

   // mixed traffic; allocation-heavy phases run the pool full and keep knocking
   task automatic test_random_traffic(int count, int alloc_pct, logic [BYTES_W-1:0] size);
      write_block_size(size);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < alloc_pct)
            send_request(KIND_ALLOC, IDX_W'($urandom_range(127)));
         else
            send_request(KIND_RELEASE, busy_block_or_noise());
         // now and then let the pipeline run dry mid-phase
         if ($urandom_range(99) == 0) wait_drained();
      end
   endtask

   // back-to-back beats with neither side holding off
   task automatic test_no_idle_stretch(int count);
      wait_drained();
      idle_on = 1'b0;
      test_random_traffic(count, 65, BYTES_RESET);
      wait_drained();
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_alloc_release_basics();
      test_block_size_sweep();
      // fill past full with the widest size so high blocks clip their offsets
      test_random_traffic(200, 90, 17'd131071);
      test_random_traffic(150, 30, 17'd1);
      test_random_traffic(200, 60, 17'd65536);
      test_random_traffic(150, 75, 17'd0);
      test_random_traffic(200, 50, BYTES_W'($urandom));
      test_no_idle_stretch(250);
      test_random_traffic(200, 85, 17'd100000);
      test_random_traffic(200, 40, BYTES_W'($urandom));
      test_random_traffic(250, 55, BYTES_RESET);

      wait_drained();
      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
